// ----- rtl/exrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix package
// Shared widths, CORDIC constants and rounding helpers.
// ----------------------------------------------------------------------------
package exrm_pkg;

   localparam int CordicSteps = 20;
   localparam int StepWidth   = 5;
   localparam int AngWidth    = 28;
   localparam int XyWidth     = 33;
   localparam int Q14Width    = 16;
   localparam int ProdWidth   = 48;

   localparam logic signed [AngWidth-1:0] AngPi     = 28'sd52707179;
   localparam logic signed [AngWidth-1:0] AngHalfPi = 28'sd26353589;
   localparam logic signed [XyWidth-1:0]  CordicGain = 33'sd652032874;

   typedef logic signed [Q14Width-1:0] q14_type;

   typedef struct packed {
      q14_type sin_x;
      q14_type cos_x;
      q14_type sin_y;
      q14_type cos_y;
      q14_type sin_z;
      q14_type cos_z;
   } trig_type;

   function automatic logic signed [AngWidth-1:0] atan_entry(input logic [StepWidth-1:0] idx);
      logic signed [AngWidth-1:0] val;
      case (idx)
         5'd0:    val = 28'sd13176795;
         5'd1:    val = 28'sd7778716;
         5'd2:    val = 28'sd4110060;
         5'd3:    val = 28'sd2086331;
         5'd4:    val = 28'sd1047214;
         5'd5:    val = 28'sd524117;
         5'd6:    val = 28'sd262123;
         5'd7:    val = 28'sd131069;
         default: val = AngWidth'(32'sd65536 >>> (idx - 5'd8));
      endcase
      return val;
   endfunction

   function automatic q14_type round_q30(input logic signed [XyWidth-1:0] v);
      logic signed [XyWidth-1:0] r;
      r = (v + XyWidth'(33'sd32768)) >>> 16;
      if (r > XyWidth'(33'sd16384)) begin
         r = XyWidth'(33'sd16384);
      end else if (r < -XyWidth'(33'sd16384)) begin
         r = -XyWidth'(33'sd16384);
      end
      return r[Q14Width-1:0];
   endfunction

   function automatic q14_type round_q42(input logic signed [ProdWidth-1:0] v);
      logic signed [ProdWidth-1:0] r;
      r = (v + ProdWidth'(48'sd134217728)) >>> 28;
      if (r > ProdWidth'(48'sd16384)) begin
         r = ProdWidth'(48'sd16384);
      end else if (r < -ProdWidth'(48'sd16384)) begin
         r = -ProdWidth'(48'sd16384);
      end
      return r[Q14Width-1:0];
   endfunction

endpackage

// ----- rtl/exrm_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Folds the angle into the right half plane, then runs one stage per step.
// ----------------------------------------------------------------------------
module exrm_cordic (
   input  logic                  clock,
   input  logic                  advance,
   input  logic signed [15:0]    angle,
   output exrm_pkg::q14_type     sin_out,
   output exrm_pkg::q14_type     cos_out
);

   localparam int N = exrm_pkg::CordicSteps;

   logic signed [exrm_pkg::XyWidth-1:0]  x_ff [N+1];
   logic signed [exrm_pkg::XyWidth-1:0]  y_ff [N+1];
   logic signed [exrm_pkg::AngWidth-1:0] a_ff [N+1];
   logic                                 neg_ff [N+1];
   logic signed [exrm_pkg::AngWidth-1:0] a_in;
   logic                                 neg_in;
   exrm_pkg::q14_type                    sin_ff, cos_ff;

   always_comb begin
      a_in   = exrm_pkg::AngWidth'(angle) <<< 11;
      neg_in = 1'b0;
      if (a_in > exrm_pkg::AngHalfPi) begin
         a_in   = a_in - exrm_pkg::AngPi;
         neg_in = 1'b1;
      end else if (a_in < -exrm_pkg::AngHalfPi) begin
         a_in   = a_in + exrm_pkg::AngPi;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= exrm_pkg::CordicGain;
         y_ff[0]   <= '0;
         a_ff[0]   <= a_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!a_ff[i][exrm_pkg::AngWidth-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - exrm_pkg::atan_entry(exrm_pkg::StepWidth'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + exrm_pkg::atan_entry(exrm_pkg::StepWidth'(i));
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= exrm_pkg::round_q30(neg_ff[N] ? -x_ff[N] : x_ff[N]);
         sin_ff <= exrm_pkg::round_q30(neg_ff[N] ? -y_ff[N] : y_ff[N]);
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ----- rtl/exrm_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix products
// Forms the nine elements over three stages: pair products, triple products
// with sums, then rounding to Q1.14.
// ----------------------------------------------------------------------------
module exrm_matrix (
   input  logic                 clock,
   input  logic                 advance,
   input  exrm_pkg::trig_type   trig,
   output exrm_pkg::q14_type    elem [9]
);

   localparam int P = exrm_pkg::ProdWidth;

   logic signed [31:0] sysx_ff, sycx_ff, szcx_ff, sxsz_ff, cxcz_ff, sxcz_ff;
   logic signed [31:0] czcy_ff, szcy_ff, sy_ff, cysx_ff, cycx_ff;
   exrm_pkg::q14_type  cz_ff, sz_ff;
   logic signed [P-1:0] m_ff [9];
   exrm_pkg::q14_type   out_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         sysx_ff <= 32'(trig.sin_y) * 32'(trig.sin_x);
         sycx_ff <= 32'(trig.sin_y) * 32'(trig.cos_x);
         szcx_ff <= 32'(trig.sin_z) * 32'(trig.cos_x);
         sxsz_ff <= 32'(trig.sin_x) * 32'(trig.sin_z);
         cxcz_ff <= 32'(trig.cos_x) * 32'(trig.cos_z);
         sxcz_ff <= 32'(trig.sin_x) * 32'(trig.cos_z);
         czcy_ff <= 32'(trig.cos_z) * 32'(trig.cos_y);
         szcy_ff <= 32'(trig.sin_z) * 32'(trig.cos_y);
         cysx_ff <= 32'(trig.cos_y) * 32'(trig.sin_x);
         cycx_ff <= 32'(trig.cos_y) * 32'(trig.cos_x);
         sy_ff   <= 32'(trig.sin_y);
         cz_ff   <= trig.cos_z;
         sz_ff   <= trig.sin_z;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff[0] <= P'(czcy_ff) <<< 14;
         m_ff[1] <= P'(sysx_ff) * P'(cz_ff) - (P'(szcx_ff) <<< 14);
         m_ff[2] <= P'(sycx_ff) * P'(cz_ff) + (P'(sxsz_ff) <<< 14);
         m_ff[3] <= P'(szcy_ff) <<< 14;
         m_ff[4] <= P'(sysx_ff) * P'(sz_ff) + (P'(cxcz_ff) <<< 14);
         m_ff[5] <= P'(sycx_ff) * P'(sz_ff) - (P'(sxcz_ff) <<< 14);
         m_ff[6] <= -(P'(sy_ff) <<< 28);
         m_ff[7] <= P'(cysx_ff) <<< 14;
         m_ff[8] <= P'(cycx_ff) <<< 14;
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_round
      always_ff @(posedge clock) begin
         if (advance) begin
            out_ff[k] <= exrm_pkg::round_q42(m_ff[k]);
         end
      end
      assign elem[k] = out_ff[k];
   end

endmodule

// ----- rtl/euler_xyz_to_rotation_matrix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angles to rotation matrix
// Converts X, Y and Z angles in Q3.13 radians to the matrix Rz*Ry*Rx in Q1.14.
// ----------------------------------------------------------------------------
// The unit takes one angle triple every cycle unless the result word is stalled, and
// returns its matrix through one stage to fold the angle, twenty CORDIC stages, one
// rounding stage, and three stages of matrix products and final rounding. The whole
// pipeline freezes while the result word is stalled.
module euler_xyz_to_rotation_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_row0_col0,
   output logic signed [15:0] rsp_row0_col1,
   output logic signed [15:0] rsp_row0_col2,
   output logic signed [15:0] rsp_row1_col0,
   output logic signed [15:0] rsp_row1_col1,
   output logic signed [15:0] rsp_row1_col2,
   output logic signed [15:0] rsp_row2_col0,
   output logic signed [15:0] rsp_row2_col1,
   output logic signed [15:0] rsp_row2_col2
);

   localparam int Depth = exrm_pkg::CordicSteps + 5;

   logic [Depth-1:0]   valid_ff;
   logic [Depth-1:0]   valid_in;
   logic               advance;
   exrm_pkg::trig_type trig;
   exrm_pkg::q14_type  elem [9];

   assign advance   = !(valid_ff[Depth-1] && rsp_stall);
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   exrm_cordic u_cordic_x (.clock, .advance, .angle(req_angle_x),
                           .sin_out(trig.sin_x), .cos_out(trig.cos_x));
   exrm_cordic u_cordic_y (.clock, .advance, .angle(req_angle_y),
                           .sin_out(trig.sin_y), .cos_out(trig.cos_y));
   exrm_cordic u_cordic_z (.clock, .advance, .angle(req_angle_z),
                           .sin_out(trig.sin_z), .cos_out(trig.cos_z));

   exrm_matrix u_matrix (.clock, .advance, .trig, .elem);

   assign rsp_valid     = valid_ff[Depth-1];
   assign rsp_row0_col0 = elem[0];
   assign rsp_row0_col1 = elem[1];
   assign rsp_row0_col2 = elem[2];
   assign rsp_row1_col0 = elem[3];
   assign rsp_row1_col1 = elem[4];
   assign rsp_row1_col2 = elem[5];
   assign rsp_row2_col0 = elem[6];
   assign rsp_row2_col1 = elem[7];
   assign rsp_row2_col2 = elem[8];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row1_col1))
      else $error("result changed while stalled");

   a_req_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall |=> valid_ff[0])
      else $error("accepted word not tracked");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix testbench
// Drives angle triples into the unit with random bursts and output stalls,
// predicts each rotation matrix with a bit-exact CORDIC model and checks it.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int Period     = 20;
   localparam int IdleLimit  = 5000;
   localparam int DrainCycles = 60;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_angle_x = '0;
   logic signed [15:0] req_angle_y = '0;
   logic signed [15:0] req_angle_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_m [9];

   matrix_word_type expected_matrices [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit stall_random = 1'b1;

   always begin
      #(Period / 2) clock = 1'b1;
      #(Period / 2) clock = 1'b0;
   end

   euler_xyz_to_rotation_matrix_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y), .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_row0_col0(rsp_m[0]), .rsp_row0_col1(rsp_m[1]), .rsp_row0_col2(rsp_m[2]),
      .rsp_row1_col0(rsp_m[3]), .rsp_row1_col1(rsp_m[4]), .rsp_row1_col2(rsp_m[5]),
      .rsp_row2_col0(rsp_m[6]), .rsp_row2_col1(rsp_m[7]), .rsp_row2_col2(rsp_m[8])
   );

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_clip(longint v, int s);
      longint r;
      r = floor_shr(v + (longint'(1) << (s - 1)), s);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic longint atan_step(int i);
      longint tbl [8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069};
      if (i < 8) return tbl[i];
      return longint'(65536) >>> (i - 8);
   endfunction

   task automatic cordic_sin_cos(input logic signed [15:0] raw, output longint s,
                                 output longint c);
      longint a, x, y, dx, dy;
      bit flip;
      a = longint'(raw) * 2048;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (a > 26353589) begin
         a -= 52707179;
         flip = 1'b1;
      end else if (a < -26353589) begin
         a += 52707179;
         flip = 1'b1;
      end
      for (int i = 0; i < 20; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (a >= 0) begin
            x -= dx; y += dy; a -= atan_step(i);
         end else begin
            x += dx; y -= dy; a += atan_step(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = round_clip(x, 16);
      s = round_clip(y, 16);
   endtask

   task automatic predict_matrix(input logic signed [15:0] ax, ay, az,
                                 output matrix_word_type w);
      longint sx, cx, sy, cy, sz, cz;
      longint p [9];
      cordic_sin_cos(ax, sx, cx);
      cordic_sin_cos(ay, sy, cy);
      cordic_sin_cos(az, sz, cz);
      p[0] = cz * cy * 16384;
      p[1] = sy * sx * cz - sz * cx * 16384;
      p[2] = cz * sy * cx + sx * sz * 16384;
      p[3] = sz * cy * 16384;
      p[4] = sz * sy * sx + cx * cz * 16384;
      p[5] = sz * sy * cx - sx * cz * 16384;
      p[6] = -sy * 16384 * 16384;
      p[7] = cy * sx * 16384;
      p[8] = cy * cx * 16384;
      for (int k = 0; k < 9; k++) w.m[k] = 16'(round_clip(p[k], 28));
   endtask

   task automatic send_angles(input logic signed [15:0] ax, ay, az);
      matrix_word_type w;
      predict_matrix(ax, ay, az, w);
      req_valid <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_matrices.push_back(w);
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // The sender keeps valid high through a burst and drops it only between bursts.
   task automatic send_burst(input int count, input bit directed_range);
      logic signed [15:0] a [3];
      int burst;
      burst = $urandom_range(1, 12);
      for (int n = 0; n < count; n++) begin
         for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 9))
               0: a[j] = 16'($urandom);
               1: a[j] = 16'(12868 + $urandom_range(0, 2) - 1);
               2: a[j] = 16'(-12868 + $urandom_range(0, 2) - 1);
               default: a[j] = directed_range ? 16'($urandom_range(0, 51472) - 25736)
                                              : 16'($urandom);
            endcase
         end
         send_angles(a[0], a[1], a[2]);
         if (--burst == 0) begin
            pause_sender();
            burst = $urandom_range(1, 12);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic test_directed_angles();
      logic signed [15:0] v [12] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
         -16'sd12868, 16'sd12869, -16'sd12869, 16'sd32767, -16'sd32768,
         16'sd6434, -16'sd6434, 16'sd1};
      for (int i = 0; i < 12; i++) send_angles(v[i], v[(i + 3) % 12], v[(i + 7) % 12]);
      send_angles(16'sd12868, 16'sd12868, 16'sd12868);
      send_angles(-16'sd32768, 16'sd32767, -16'sd25736);
      req_valid <= 1'b0;
   endtask

   task automatic test_random_angles();
      send_burst(250, 1'b1);
   endtask

   task automatic test_full_pipeline_hold();
      hold_off = 1'b1;
      send_burst(60, 1'b1);
   endtask

   task automatic test_streaming_no_gaps();
      stall_random = 1'b0;
      for (int n = 0; n < 80; n++)
         send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      req_valid <= 1'b0;
      stall_random = 1'b1;
      send_burst(150, 1'b1);
   endtask

   // Output stall pattern with its own long hold-off when requested.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         repeat (200) @(posedge clock);
         hold_off = 1'b0;
         rsp_stall <= 1'b0;
      end else if (!stall_random) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      matrix_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matrices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result word");
         end else begin
            w = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (rsp_m[k] !== w.m[k]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Element %0d: expected %0d, got %0d", k, w.m[k], rsp_m[k]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_angles();
      test_random_angles();
      test_full_pipeline_hold();
      test_streaming_no_gaps();
      waited = 0;
      while (expected_matrices.size() != 0 && waited < IdleLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_matrices.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
